// ----- rtl/isd_pkg.sv -----
// ----------------------------------------------------------------------------
// isd_pkg: shared types and constants for the irrigation dispatch unit
// Schedule entry layout, register indexes, codes, command/status bundles.
// ----------------------------------------------------------------------------
package isd_pkg;

  // Default build sizes
  localparam int DEF_SCHED_SLOTS  = 4;
  localparam int DEF_PUMP_COUNT   = 4;
  localparam int DEF_SENSOR_COUNT = 4;

  // Fixed widths
  localparam int NUM_SLOT_REGS = 4;
  localparam int SLOT_W        = 2;
  localparam int MIN_W         = 11;
  localparam int DAY_MINUTES   = 1440;
  localparam int SENSOR_MAX    = 4;
  localparam int MOIST_W       = 7;
  localparam int MSUM_W        = 9;
  localparam int PORT_W        = 8;
  localparam int MS_W          = 16;
  localparam int PPD_W         = 8;
  localparam int PROD1_W       = PORT_W + MS_W;
  localparam int RUN_W         = 32;
  localparam int CFG_W         = 54;
  localparam int CFG_IDX_W     = 3;
  localparam int PIDX_OUT_W    = 2;
  localparam int DIV_STEPS     = MIN_W;
  localparam int DIV_CNT_W     = 4;
  localparam int MEAN_SHIFT    = 12;
  localparam int MEAN_PROD_W   = MSUM_W + MEAN_SHIFT + 1;

  localparam logic [MIN_W-1:0]  LAST_MIN_NONE   = 11'd2047;
  localparam logic [MS_W-1:0]   MS_PER_PORT_RST = 16'd1000;
  localparam logic [PPD_W-1:0]  PPD_RST         = 8'd1;

  // Register indexes on the config port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCHED_0,
    CFG_SCHED_1,
    CFG_SCHED_2,
    CFG_SCHED_3,
    CFG_MS_PER_PORTION,
    CFG_PORTIONS_PER_DOSE,
    CFG_PRIME_MS
  } cfg_idx_t;

  // Moisture condition codes
  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_BELOW,
    COND_ABOVE,
    COND_NEVER
  } cond_t;

  // One packed schedule slot, LSB = start minute
  typedef struct packed {
    logic [7:0]       mask;
    logic [PORT_W-1:0] portions;
    logic [7:0]       thr;
    logic             active;
    cond_t            cond;
    logic [4:0]       sensor;
    logic [MIN_W-1:0] rpt;
    logic [MIN_W-1:0] start;
  } sched_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SLOT,
    ST_MOD,
    ST_APPLY,
    ST_MUL2,
    ST_OUT
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;
    logic mark_minute;
    logic slot_next;
    logic mod_start;
    logic mod_step;
    logic fire;
    logic disp_start;
    logic mul2;
    logic emit;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic mode;
    logic minute_new;
    logic disp_ok;
    logic pre_ok;
    logic rep_zero;
    logic diff_zero;
    logic mod_last;
    logic rem_zero;
    logic slot_last;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/isd_ctrl.sv -----
// ----------------------------------------------------------------------------
// isd_ctrl: sequencer for the irrigation dispatch unit
// Walks schedule slots, runs the remainder steps and the run-time multiply.
// ----------------------------------------------------------------------------
module isd_ctrl import isd_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  sts_t   sts,
  output cmd_t   cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        if (!sts.mode) begin
          state_nxt = sts.minute_new ? ST_SLOT : ST_IDLE;
        end else begin
          state_nxt = sts.disp_ok ? ST_MUL2 : ST_IDLE;
        end
      end
      ST_SLOT: begin
        if (!sts.pre_ok || sts.rep_zero) begin
          state_nxt = sts.slot_last ? ST_IDLE : ST_SLOT;
        end else begin
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        if (sts.mod_last) state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        state_nxt = sts.slot_last ? ST_IDLE : ST_SLOT;
      end
      ST_MUL2: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_DECODE: begin
        if (!sts.mode) begin
          cmd.mark_minute = sts.minute_new;
        end else begin
          cmd.disp_start = sts.disp_ok;
        end
      end
      ST_SLOT: begin
        if (!sts.pre_ok) begin
          cmd.slot_next = 1'b1;
        end else if (sts.rep_zero) begin
          cmd.fire      = sts.diff_zero;
          cmd.slot_next = 1'b1;
        end else begin
          cmd.mod_start = 1'b1;
        end
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
      end
      ST_APPLY: begin
        cmd.fire      = sts.rem_zero;
        cmd.slot_next = 1'b1;
      end
      ST_MUL2: begin
        cmd.mul2 = 1'b1;
      end
      ST_OUT: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- rtl/isd_dp.sv -----
// ----------------------------------------------------------------------------
// isd_dp: datapath of the irrigation dispatch unit
// Config registers, schedule match, remainder unit, pending pumps, run time.
// ----------------------------------------------------------------------------
module isd_dp import isd_pkg::*; #(
  parameter int SCHED_SLOTS  = DEF_SCHED_SLOTS,
  parameter int PUMP_COUNT   = DEF_PUMP_COUNT,
  parameter int SENSOR_COUNT = DEF_SENSOR_COUNT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  in_mode,
  input  logic [MIN_W-1:0]      in_minute_of_day,
  input  logic                  in_clock_valid,
  input  logic [MOIST_W-1:0]    in_moisture_0,
  input  logic [MOIST_W-1:0]    in_moisture_1,
  input  logic [MOIST_W-1:0]    in_moisture_2,
  input  logic [MOIST_W-1:0]    in_moisture_3,
  input  logic                  in_pumps_busy,
  input  logic                  in_power_ok,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIDX_OUT_W-1:0] out_pump_index,
  output logic [RUN_W-1:0]      out_run_ms
);

  localparam int PUMP_W = (PUMP_COUNT > 1) ? $clog2(PUMP_COUNT) : 1;
  localparam int RECIP  = ((1 << MEAN_SHIFT) + SENSOR_COUNT - 1) / SENSOR_COUNT;

  // Config
  sched_t             sched_r [NUM_SLOT_REGS];
  logic [MS_W-1:0]    ms_r;
  logic [PPD_W-1:0]   ppd_r;
  logic [MS_W-1:0]    prime_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOT_REGS; i++) sched_r[i] <= '0;
      ms_r    <= MS_PER_PORT_RST;
      ppd_r   <= PPD_RST;
      prime_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SCHED_0:           sched_r[0] <= sched_t'(cfg_wdata);
        CFG_SCHED_1:           sched_r[1] <= sched_t'(cfg_wdata);
        CFG_SCHED_2:           sched_r[2] <= sched_t'(cfg_wdata);
        CFG_SCHED_3:           sched_r[3] <= sched_t'(cfg_wdata);
        CFG_MS_PER_PORTION:    ms_r       <= cfg_wdata[MS_W-1:0];
        CFG_PORTIONS_PER_DOSE: ppd_r      <= cfg_wdata[PPD_W-1:0];
        CFG_PRIME_MS:          prime_r    <= cfg_wdata[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured word
  logic               mode_r, clock_valid_r, pumps_busy_r, power_ok_r;
  logic [MIN_W-1:0]   minute_r;
  logic [MOIST_W-1:0] moist_r [SENSOR_MAX];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r        <= in_mode;
      minute_r      <= in_minute_of_day;
      clock_valid_r <= in_clock_valid;
      pumps_busy_r  <= in_pumps_busy;
      power_ok_r    <= in_power_ok;
      moist_r[0]    <= in_moisture_0;
      moist_r[1]    <= in_moisture_1;
      moist_r[2]    <= in_moisture_2;
      moist_r[3]    <= in_moisture_3;
    end
  end

  // Mean moisture, multiply by reciprocal, registered
  logic [MSUM_W-1:0]      msum;
  logic [MEAN_PROD_W-1:0] mprod;
  logic [MOIST_W-1:0]     mean_nxt, mean_r;

  always_comb begin
    msum = '0;
    for (int k = 0; k < SENSOR_COUNT; k++) msum = msum + MSUM_W'(moist_r[k]);
    mprod    = MEAN_PROD_W'(msum) * MEAN_PROD_W'(RECIP);
    mean_nxt = MOIST_W'(mprod >> MEAN_SHIFT);
  end

  always_ff @(posedge clk) begin
    mean_r <= mean_nxt;
  end

  // Last minute and slot pointer
  logic [MIN_W-1:0]  last_r;
  logic [SLOT_W-1:0] slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= LAST_MIN_NONE;
      slot_r <= '0;
    end else begin
      if (cmd.mark_minute) begin
        last_r <= minute_r;
        slot_r <= '0;
      end else if (cmd.slot_next) begin
        slot_r <= slot_r + 1'b1;
      end
    end
  end

  // Current slot match
  sched_t             cur;
  logic [MIN_W-1:0]   diff;
  logic [4:0]         sel_m1;
  logic [MOIST_W-1:0] msel;
  logic               cond_ok;

  always_comb begin
    cur    = sched_r[slot_r];
    diff   = minute_r - cur.start;
    sel_m1 = cur.sensor - 5'd1;
    msel   = (cur.sensor == 5'd0) ? mean_r : moist_r[sel_m1[1:0]];
    case (cur.cond)
      COND_ALWAYS: cond_ok = 1'b1;
      COND_BELOW:  cond_ok = (cur.sensor <= 5'(SENSOR_COUNT)) && ({1'b0, msel} < cur.thr);
      COND_ABOVE:  cond_ok = (cur.sensor <= 5'(SENSOR_COUNT)) && ({1'b0, msel} > cur.thr);
      COND_NEVER:  cond_ok = 1'b0;
      default:     cond_ok = 1'b0;
    endcase
  end

  // Remainder unit: restoring, one quotient bit per cycle
  logic [MIN_W-1:0]     rem_r, dvd_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [MIN_W:0]       rtrial;

  assign rtrial = {rem_r, dvd_r[MIN_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.mod_start) begin
      rem_r <= '0;
      dvd_r <= diff;
      cnt_r <= '0;
    end else if (cmd.mod_step) begin
      if (rtrial >= {1'b0, cur.rpt}) begin
        rem_r <= MIN_W'(rtrial - {1'b0, cur.rpt});
      end else begin
        rem_r <= rtrial[MIN_W-1:0];
      end
      dvd_r <= {dvd_r[MIN_W-2:0], 1'b0};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Pending pumps
  logic              pend_r [PUMP_COUNT];
  logic [PORT_W-1:0] port_r [PUMP_COUNT];
  logic [PUMP_W-1:0] first;
  logic              any_pend;

  always_comb begin
    first    = '0;
    any_pend = 1'b0;
    for (int i = PUMP_COUNT - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        first    = PUMP_W'(i);
        any_pend = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PUMP_COUNT; i++) begin
        pend_r[i] <= 1'b0;
        port_r[i] <= '0;
      end
    end else if (cmd.fire) begin
      for (int i = 0; i < PUMP_COUNT; i++) begin
        if (cur.mask[i]) begin
          pend_r[i] <= 1'b1;
          port_r[i] <= cur.portions;
        end
      end
    end else if (cmd.disp_start) begin
      pend_r[first] <= 1'b0;
    end
  end

  // Run time: two registered multiplies, then saturating add
  logic [PORT_W-1:0]  nclamp;
  logic [PUMP_W-1:0]  pidx_r;
  logic [PROD1_W-1:0] prod1_r;
  logic [RUN_W-1:0]   prod2_r;
  logic [RUN_W:0]     run_sum;

  assign nclamp  = (port_r[first] == '0) ? PORT_W'(1) : port_r[first];
  assign run_sum = {1'b0, prod2_r} + (RUN_W + 1)'(prime_r);

  always_ff @(posedge clk) begin
    if (cmd.disp_start) begin
      pidx_r  <= first;
      prod1_r <= PROD1_W'(nclamp) * PROD1_W'(ms_r);
    end
    if (cmd.mul2) begin
      prod2_r <= RUN_W'(prod1_r) * RUN_W'(ppd_r);
    end
  end

  // Output register
  logic                  out_valid_r;
  logic [PIDX_OUT_W-1:0] out_pidx_r;
  logic [RUN_W-1:0]      out_run_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_pidx_r <= PIDX_OUT_W'(pidx_r);
      out_run_r  <= run_sum[RUN_W] ? '1 : run_sum[RUN_W-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pump_index = out_pidx_r;
  assign out_run_ms     = out_run_r;

  // Status
  always_comb begin
    sts            = '0;
    sts.mode       = mode_r;
    sts.minute_new = clock_valid_r && (minute_r != last_r);
    sts.disp_ok    = power_ok_r && !pumps_busy_r && any_pend;
    sts.pre_ok     = cur.active && (minute_r >= cur.start) &&
                     (diff < MIN_W'(DAY_MINUTES)) && cond_ok;
    sts.rep_zero   = (cur.rpt == '0);
    sts.diff_zero  = (diff == '0);
    sts.mod_last   = (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
    sts.rem_zero   = (rem_r == '0);
    sts.slot_last  = (slot_r == SLOT_W'(SCHED_SLOTS - 1));
    sts.out_free   = !out_valid_r || out_ready;
  end

endmodule

// ----- rtl/irrigation_schedule_dispatch_unit.sv -----
// ----------------------------------------------------------------------------
// irrigation_schedule_dispatch_unit: schedule check and pump dispatch
// Top level: sequencer plus datapath.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready) carries one word per event. mode 0 is
//    a minute tick: it walks the schedule slots and marks pumps pending.
//    mode 1 is a dispatch check: it starts the lowest pending pump.
//  - Output channel (out_valid/out_ready) carries pump_index and run_ms,
//    only for a dispatch that starts a pump. Minute ticks give no word.
//  - Config port: cfg_wr_en writes cfg_wdata to register cfg_index at once.
//    Write only while idle. Unknown indexes are dropped.
//  - Timing: one word at a time. A minute tick walks the slots in turn; a
//    slot that is inactive, does not match or has a zero repeat is settled in
//    its slot state, else it runs an 11-step bit-serial remainder of the
//    minute distance by the repeat period. A dispatch runs decode with the
//    first multiply, then the second multiply, then the saturating add to
//    the output register.
//  - Stall: a waiting result sits in the output register; new words are
//    taken meanwhile, and only a second dispatch result waits for room.
//  - Reset (rst_n low, synchronous): registers to defaults, no pump
//    pending, no minute seen, output empty.
// ----------------------------------------------------------------------------
module irrigation_schedule_dispatch_unit import isd_pkg::*; #(
  parameter int SCHED_SLOTS  = DEF_SCHED_SLOTS,
  parameter int PUMP_COUNT   = DEF_PUMP_COUNT,
  parameter int SENSOR_COUNT = DEF_SENSOR_COUNT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // config port
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_mode,
  input  logic [MIN_W-1:0]      in_minute_of_day,
  input  logic                  in_clock_valid,
  input  logic [MOIST_W-1:0]    in_moisture_0,
  input  logic [MOIST_W-1:0]    in_moisture_1,
  input  logic [MOIST_W-1:0]    in_moisture_2,
  input  logic [MOIST_W-1:0]    in_moisture_3,
  input  logic                  in_pumps_busy,
  input  logic                  in_power_ok,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIDX_OUT_W-1:0] out_pump_index,
  output logic [RUN_W-1:0]      out_run_ms
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer: slot walk, remainder steps, dispatch multiply
  isd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: config, match logic, pending pumps, run time, output register
  isd_dp #(
    .SCHED_SLOTS  (SCHED_SLOTS),
    .PUMP_COUNT   (PUMP_COUNT),
    .SENSOR_COUNT (SENSOR_COUNT)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_mode          (in_mode),
    .in_minute_of_day (in_minute_of_day),
    .in_clock_valid   (in_clock_valid),
    .in_moisture_0    (in_moisture_0),
    .in_moisture_1    (in_moisture_1),
    .in_moisture_2    (in_moisture_2),
    .in_moisture_3    (in_moisture_3),
    .in_pumps_busy    (in_pumps_busy),
    .in_power_ok      (in_power_ok),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pump_index   (out_pump_index),
    .out_run_ms       (out_run_ms)
  );

  // A result is only loaded when the output register has room
  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken word");

  // Output valid only rises from a load
  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.emit))
    else $error("output valid rose without a load");

  // Remainder unit, once started, steps in the next cycle
  a_mod_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mod_start |=> cmd.mod_step)
    else $error("remainder unit started but not stepped");

endmodule

// ----- verif/irrigation_schedule_dispatch_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irrigation_schedule_dispatch_unit_tb: self-checking bench for the dispatch unit
// Drives minute ticks and dispatch checks through the input channel. A local
// copy of the schedule, pending flags and portion counts predicts every pump
// start, and each result word is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module irrigation_schedule_dispatch_unit_tb;
  import isd_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 7;
  localparam int SLOTS        = DEF_SCHED_SLOTS;
  localparam int PUMPS        = DEF_PUMP_COUNT;
  localparam int SENSORS      = DEF_SENSOR_COUNT;
  localparam int IDLE_PCT     = 15;
  localparam int RAND_WORDS   = 1500;
  localparam int NUM_PHASES   = 8;
  // settle time for a minute tick to walk all four slots, with margin
  localparam int TAIL_CYCLES  = 80;
  localparam int STALL_LIMIT  = 5000;

  localparam logic MODE_TICK     = 1'b0;
  localparam logic MODE_DISPATCH = 1'b1;
  // index 7 is not a register: the write must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = '1;

  // one input word as the bench sees it
  typedef struct packed {
    logic                          mode;
    logic [MIN_W-1:0]              minute;
    logic                          clk_ok;
    logic [3:0][MOIST_W-1:0]       moist;
    logic                          busy;
    logic                          power;
  } word_t;

  // queued word; hold_for_drain keeps it back until all pump starts are in
  typedef struct {
    word_t w;
    bit    hold_for_drain;
  } queued_word_t;

  typedef struct packed {
    logic [PIDX_OUT_W-1:0] pump;
    logic [RUN_W-1:0]      run_ms;
  } pump_start_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_mode;
  logic [MIN_W-1:0]      in_minute_of_day;
  logic                  in_clock_valid;
  logic [MOIST_W-1:0]    in_moisture_0;
  logic [MOIST_W-1:0]    in_moisture_1;
  logic [MOIST_W-1:0]    in_moisture_2;
  logic [MOIST_W-1:0]    in_moisture_3;
  logic                  in_pumps_busy;
  logic                  in_power_ok;
  logic                  out_valid;
  logic                  out_ready;
  logic [PIDX_OUT_W-1:0] out_pump_index;
  logic [RUN_W-1:0]      out_run_ms;

  irrigation_schedule_dispatch_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_minute_of_day (in_minute_of_day),
    .in_clock_valid   (in_clock_valid),
    .in_moisture_0    (in_moisture_0),
    .in_moisture_1    (in_moisture_1),
    .in_moisture_2    (in_moisture_2),
    .in_moisture_3    (in_moisture_3),
    .in_pumps_busy    (in_pumps_busy),
    .in_power_ok      (in_power_ok),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pump_index   (out_pump_index),
    .out_run_ms       (out_run_ms)
  );

  // --------------------------------------------------------------------------
  // Shadow of the block: schedule registers, dose settings, pump state
  // --------------------------------------------------------------------------
  sched_t            slot_cfg [NUM_SLOT_REGS];
  logic [MS_W-1:0]   ms_per_portion_r;
  logic [PPD_W-1:0]  dose_mult;
  logic [MS_W-1:0]   prime_extra;
  bit                pump_due   [PUMPS];
  logic [PORT_W-1:0] dose_count [PUMPS];
  logic [MIN_W-1:0]  last_tick_min;

  queued_word_t word_q [$];        // words not yet accepted, head is on the pins
  pump_start_t  pump_start_q [$];  // predicted pump starts, oldest first

  bit calm;           // no idling on either side while set
  bit word_taken;     // head word was accepted at the last rising edge
  int fail_cnt;
  int stall_cycles;

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Update the shadow state for one accepted word; queue a pump start if any.
  task automatic track_word(input word_t w);
    sched_t          s;
    int unsigned     span;
    int unsigned     level;
    bit              hit;
    bit              met;
    bit              started;
    longint unsigned run;
    pump_start_t     start_r;
    if (w.mode == MODE_TICK) begin
      // unsynced clock or a repeated minute: no effect at all
      if (!w.clk_ok || w.minute == last_tick_min) return;
      last_tick_min = w.minute;
      for (int i = 0; i < SLOTS; i++) begin
        s = slot_cfg[i];
        hit = 1'b0;
        // slot start after the minute, or a day or more behind it: no hit
        if (s.active && s.start <= w.minute) begin
          span = w.minute - s.start;
          if (span < DAY_MINUTES)
            hit = (s.rpt == 0) ? (span == 0) : ((span % s.rpt) == 0);
        end
        case (s.cond)
          COND_ALWAYS: met = 1'b1;
          COND_NEVER:  met = 1'b0;
          default: begin
            // sensor number past the fitted sensors reads as false
            met = 1'b0;
            if (s.sensor <= SENSORS) begin
              if (s.sensor == 0) begin
                level = 0;
                for (int k = 0; k < SENSORS; k++) level += w.moist[k];
                level = level / SENSORS;
              end else begin
                level = w.moist[s.sensor - 1];
              end
              met = (s.cond == COND_BELOW) ? (level < s.thr) : (level > s.thr);
            end
          end
        endcase
        // later slots overwrite the portion count; mask bits past the pumps drop
        if (hit && met) begin
          for (int p = 0; p < PUMPS; p++) begin
            if (s.mask[p]) begin
              pump_due[p]   = 1'b1;
              dose_count[p] = s.portions;
            end
          end
        end
      end
      return;
    end
    // dispatch: needs supply and an idle pump set, lowest pending pump wins
    if (!w.power || w.busy) return;
    started = 1'b0;
    for (int p = 0; p < PUMPS; p++) begin
      if (!started && pump_due[p]) begin
        run = (dose_count[p] == 0) ? 1 : dose_count[p];
        run = run * ms_per_portion_r * dose_mult + prime_extra;
        if (run > 64'hFFFF_FFFF) run = 64'hFFFF_FFFF;
        pump_due[p]    = 1'b0;
        start_r.pump   = PIDX_OUT_W'(p);
        start_r.run_ms = run[RUN_W-1:0];
        pump_start_q.push_back(start_r);
        started = 1'b1;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [CFG_W-1:0] slot_word(
    input logic [MIN_W-1:0]  start,
    input logic [MIN_W-1:0]  rpt,
    input logic              act,
    input cond_t             cond,
    input logic [4:0]        sensor,
    input logic [7:0]        thr,
    input logic [PORT_W-1:0] portions,
    input logic [7:0]        mask
  );
    sched_t s;
    s.start    = start;
    s.rpt      = rpt;
    s.active   = act;
    s.cond     = cond;
    s.sensor   = sensor;
    s.thr      = thr;
    s.portions = portions;
    s.mask     = mask;
    return s;
  endfunction

  function automatic logic [CFG_W-1:0] rand_slot();
    logic [MIN_W-1:0] rpt;
    case ($urandom_range(9))
      0, 1:          rpt = '0;
      2, 3, 4, 5, 6: rpt = MIN_W'($urandom_range(60, 1));
      7, 8:          rpt = MIN_W'($urandom_range(1439, 61));
      default:       rpt = MIN_W'($urandom_range(2047));
    endcase
    return slot_word(
      MIN_W'(($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(1439)),
      rpt,
      $urandom_range(9) != 0,
      cond_t'($urandom_range(3)),
      5'(($urandom_range(7) == 0) ? $urandom_range(31) : $urandom_range(SENSORS)),
      8'(($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(100)),
      PORT_W'(($urandom_range(9) == 0) ? 0 : $urandom_range(255)),
      8'($urandom_range(255)));
  endfunction

  function automatic word_t tick_word(input logic [MIN_W-1:0] minute, input logic ok,
                                      input int m0, input int m1, input int m2,
                                      input int m3);
    word_t w;
    w.mode     = MODE_TICK;
    w.minute   = minute;
    w.clk_ok   = ok;
    w.moist[0] = MOIST_W'(m0);
    w.moist[1] = MOIST_W'(m1);
    w.moist[2] = MOIST_W'(m2);
    w.moist[3] = MOIST_W'(m3);
    w.busy     = 1'($urandom_range(1));
    w.power    = 1'($urandom_range(1));
    return w;
  endfunction

  function automatic word_t dispatch_word(input logic busy, input logic power);
    word_t w;
    w        = tick_word(MIN_W'($urandom_range(2047)), 1'($urandom_range(1)),
                         $urandom_range(127), $urandom_range(127),
                         $urandom_range(127), $urandom_range(127));
    w.mode   = MODE_DISPATCH;
    w.busy   = busy;
    w.power  = power;
    return w;
  endfunction

  // Mostly well-formed traffic: ticks aimed at slot hit minutes and dispatch
  // checks with power up and pumps idle. The rest is raw noise.
  function automatic word_t rand_word();
    word_t            w;
    sched_t           s;
    logic [63:0]      bits;
    int unsigned      pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      s = slot_cfg[$urandom_range(NUM_SLOT_REGS - 1)];
      w = tick_word('0, 1'b1, 0, 0, 0, 0);
      for (int k = 0; k < 4; k++)
        w.moist[k] = MOIST_W'(($urandom_range(9) == 0) ? $urandom_range(127)
                                                       : $urandom_range(100));
      case ($urandom_range(9))
        7, 8:    w.minute = MIN_W'($urandom_range(1439));
        9:       w.minute = MIN_W'($urandom_range(2047));
        default: w.minute = (s.rpt == 0) ? s.start
                            : MIN_W'(s.start + s.rpt * $urandom_range(1439 / s.rpt));
      endcase
    end else if (pick < 88) begin
      w = dispatch_word(1'b0, 1'b1);
    end else begin
      bits = {$urandom, $urandom};
      w    = bits[$bits(word_t)-1:0];
    end
    return w;
  endfunction

  task automatic queue_word(input word_t w, input bit hold);
    queued_word_t q;
    q.w              = w;
    q.hold_for_drain = hold;
    word_q.push_back(q);
  endtask

  // Register write on the falling edge; the shadow copy follows at once since
  // the block is idle whenever this is called.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_SCHED_0:           slot_cfg[0]      = val;
      CFG_SCHED_1:           slot_cfg[1]      = val;
      CFG_SCHED_2:           slot_cfg[2]      = val;
      CFG_SCHED_3:           slot_cfg[3]      = val;
      CFG_MS_PER_PORTION:    ms_per_portion_r = val[MS_W-1:0];
      CFG_PORTIONS_PER_DOSE: dose_mult        = val[PPD_W-1:0];
      CFG_PRIME_MS:          prime_extra      = val[MS_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Wait until every word is taken and every pump start has come out, then
  // give a minute tick that cannot produce a word time to finish.
  task automatic settle(input int gap);
    do @(negedge clk);
    while (word_q.size() != 0 || in_valid || pump_start_q.size() != 0);
    repeat (gap) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Driver: inputs change on the falling edge. A presented word stays on the
  // pins until taken; after that the next head word or an idle cycle follows.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      if (!in_valid || word_taken) begin
        word_taken = 1'b0;
        if (word_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT) &&
            !(word_q[0].hold_for_drain && pump_start_q.size() != 0)) begin
          in_valid         <= 1'b1;
          in_mode          <= word_q[0].w.mode;
          in_minute_of_day <= word_q[0].w.minute;
          in_clock_valid   <= word_q[0].w.clk_ok;
          in_moisture_0    <= word_q[0].w.moist[0];
          in_moisture_1    <= word_q[0].w.moist[1];
          in_moisture_2    <= word_q[0].w.moist[2];
          in_moisture_3    <= word_q[0].w.moist[3];
          in_pumps_busy    <= word_q[0].w.busy;
          in_power_ok      <= word_q[0].w.power;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: samples both channels on the rising edge. Taken input words feed
  // the shadow model; result words are checked against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    word_t       got;
    pump_start_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pump_start_q.size() == 0) begin
          $error("unexpected pump start: pump_index %0d run_ms %0d",
                 out_pump_index, out_run_ms);
          fail_cnt++;
        end else begin
          want = pump_start_q.pop_front();
          if (out_pump_index !== want.pump) begin
            $error("pump_index: expected %0d, got %0d", want.pump, out_pump_index);
            fail_cnt++;
          end
          if (out_run_ms !== want.run_ms) begin
            $error("run_ms: expected %0d, got %0d", want.run_ms, out_run_ms);
            fail_cnt++;
          end
        end
      end
      if (in_valid && in_ready) begin
        got.mode     = in_mode;
        got.minute   = in_minute_of_day;
        got.clk_ok   = in_clock_valid;
        got.moist[0] = in_moisture_0;
        got.moist[1] = in_moisture_1;
        got.moist[2] = in_moisture_2;
        got.moist[3] = in_moisture_3;
        got.busy     = in_pumps_busy;
        got.power    = in_power_ok;
        track_word(got);
        word_q.delete(0);
        word_taken = 1'b1;
      end
    end
  end

  // Watchdog: cycles in a row with no handshake and no register write.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int               goal;
    int               counted;
    int               n;
    logic [MIN_W-1:0] gen_last_min;
    word_t            w;

    // all inputs known from time zero
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_index        = '0;
    cfg_wdata        = '0;
    in_valid         = 1'b0;
    in_mode          = MODE_TICK;
    in_minute_of_day = '0;
    in_clock_valid   = 1'b0;
    in_moisture_0    = '0;
    in_moisture_1    = '0;
    in_moisture_2    = '0;
    in_moisture_3    = '0;
    in_pumps_busy    = 1'b0;
    in_power_ok      = 1'b0;
    out_ready        = 1'b0;
    calm             = 1'b0;
    word_taken       = 1'b0;
    fail_cnt         = 0;

    // shadow state after reset
    for (int i = 0; i < NUM_SLOT_REGS; i++) slot_cfg[i] = '0;
    ms_per_portion_r = MS_PER_PORT_RST;
    dose_mult        = PPD_RST;
    prime_extra      = '0;
    for (int p = 0; p < PUMPS; p++) begin
      pump_due[p]   = 1'b0;
      dose_count[p] = '0;
    end
    last_tick_min = LAST_MIN_NONE;
    gen_last_min  = LAST_MIN_NONE;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // ---- directed: default settings, nothing scheduled ----
    queue_word(dispatch_word(1'b0, 1'b1), 1'b0);             // nothing pending
    queue_word(tick_word(LAST_MIN_NONE, 1'b1, 9, 9, 9, 9), 1'b0); // same as none-seen
    queue_word(tick_word(10, 1'b0, 0, 0, 0, 0), 1'b0);       // clock not synced
    settle(TAIL_CYCLES);

    // slot 0: once a day at 10, all mask bits set (upper ones ignored), zero portions
    // slot 1: every 5 from 5, mean moisture below 50, also on pump 1
    // slot 2: every minute, sensor 3 above 20, full portions on pump 2
    // slot 3: sensor number past the fitted sensors, never true
    write_reg(CFG_SCHED_0, slot_word(10, 0, 1'b1, COND_ALWAYS, 0, 0, 0, 8'hFF));
    write_reg(CFG_SCHED_1, slot_word(5, 5, 1'b1, COND_BELOW, 0, 50, 7, 8'h02));
    write_reg(CFG_SCHED_2, slot_word(0, 1, 1'b1, COND_ABOVE, 3, 20, 255, 8'h04));
    write_reg(CFG_SCHED_3, slot_word(0, 1, 1'b1, COND_BELOW, 9, 255, 9, 8'h08));
    write_reg(CFG_MS_PER_PORTION, '1);
    write_reg(CFG_PORTIONS_PER_DOSE, '1);
    write_reg(CFG_PRIME_MS, '1);
    write_reg(CFG_UNUSED_IDX, '1);

    queue_word(tick_word(10, 1'b1, 0, 0, 0, 0), 1'b0);       // slots 0 and 1 fire
    queue_word(dispatch_word(1'b0, 1'b0), 1'b0);             // no supply
    queue_word(dispatch_word(1'b1, 1'b1), 1'b0);             // pump running
    repeat (4) queue_word(dispatch_word(1'b0, 1'b1), 1'b0);  // pumps 0..3 in order
    queue_word(dispatch_word(1'b0, 1'b1), 1'b0);             // all drained
    queue_word(tick_word(10, 1'b1, 0, 0, 0, 0), 1'b0);       // repeated minute
    queue_word(dispatch_word(1'b0, 1'b1), 1'b0);
    queue_word(tick_word(14, 1'b1, 0, 0, 127, 0), 1'b0);     // moisture past 100
    queue_word(dispatch_word(1'b0, 1'b1), 1'b0);
    queue_word(tick_word(1440, 1'b1, 0, 0, 127, 0), 1'b0);   // a full day behind
    queue_word(dispatch_word(1'b0, 1'b1), 1'b0);
    queue_word(tick_word(3, 1'b1, 0, 0, 100, 0), 1'b0);      // start after minute
    queue_word(dispatch_word(1'b0, 1'b1), 1'b0);
    queue_word(tick_word(15, 1'b1, 50, 50, 20, 80), 1'b0);   // mean 50, not below
    queue_word(tick_word(20, 1'b1, 50, 49, 20, 80), 1'b0);   // mean 49, fires
    queue_word(dispatch_word(1'b0, 1'b1), 1'b0);
    settle(TAIL_CYCLES);

    write_reg(CFG_SCHED_3, slot_word(0, 1, 1'b1, COND_NEVER, 1, 255, 9, 8'h08));
    queue_word(tick_word(30, 1'b1, 0, 0, 0, 0), 1'b0);       // condition never
    queue_word(dispatch_word(1'b0, 1'b1), 1'b0);
    settle(TAIL_CYCLES);
    gen_last_min = 30;

    // ---- random phases, each with fresh settings ----
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      for (int i = 0; i < NUM_SLOT_REGS; i++) write_reg(cfg_idx_t'(i), rand_slot());
      case (ph)
        0: begin                                   // all dose settings at minimum
          write_reg(CFG_MS_PER_PORTION, '0);
          write_reg(CFG_PORTIONS_PER_DOSE, '0);
          write_reg(CFG_PRIME_MS, '0);
        end
        1: begin                                   // all at maximum
          write_reg(CFG_MS_PER_PORTION, '1);
          write_reg(CFG_PORTIONS_PER_DOSE, '1);
          write_reg(CFG_PRIME_MS, '1);
        end
        default: begin
          write_reg(CFG_MS_PER_PORTION, CFG_W'($urandom_range(65535)));
          write_reg(CFG_PORTIONS_PER_DOSE, CFG_W'($urandom_range(255)));
          write_reg(CFG_PRIME_MS,
                    CFG_W'($urandom_range(1) ? $urandom_range(65535) : 0));
        end
      endcase
      if (ph == 3) write_reg(CFG_UNUSED_IDX, CFG_W'({$urandom, $urandom}));
      calm    = (ph == 2);
      goal    = RAND_WORDS / NUM_PHASES;
      counted = 0;
      n       = 0;
      while (counted < goal) begin
        w = rand_word();
        // halfway through, hold the sender until every pump start is out
        queue_word(w, n == goal / 2);
        n++;
        // ignored ticks and refused dispatches don't count toward the total
        if (w.mode == MODE_DISPATCH) begin
          if (w.power && !w.busy) counted++;
        end else if (w.clk_ok && w.minute != gen_last_min) begin
          gen_last_min = w.minute;
          counted++;
        end
      end
      settle(TAIL_CYCLES);
    end

    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/isd_pkg.sv
rtl/isd_ctrl.sv
rtl/isd_dp.sv
rtl/irrigation_schedule_dispatch_unit.sv
verif/irrigation_schedule_dispatch_unit_tb.sv
